[rtl/dlle_pkg.sv]
// Types, codes and microprogram for the doubly linked list engine.
// No dependencies; used by the top level and the checker by scoped names.
package dlle_pkg;

    localparam int ID_W     = 7;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 16;

    typedef logic [ID_W-1:0] id_t;

    typedef enum logic [OP_W-1:0] {
        OP_INS_LEFT  = 2'd0,
        OP_INS_RIGHT = 2'd1,
        OP_REMOVE    = 2'd2,
        OP_WALK      = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE       = 2'd0,
        ST_BAD_INSERT = 2'd1,
        ST_ABSENT     = 2'd2
    } status_t;

    // microprogram step addresses
    typedef logic [3:0] step_t;
    localparam step_t S_FETCH   = 4'd0;
    localparam step_t S_INS_RD  = 4'd1;
    localparam step_t S_INS_W1  = 4'd2;
    localparam step_t S_INS_W2  = 4'd3;
    localparam step_t S_REM_RD  = 4'd4;
    localparam step_t S_REM_W   = 4'd5;
    localparam step_t S_EMIT    = 4'd6;
    localparam step_t S_WALK_ST = 4'd7;
    localparam step_t S_WALK_RD = 4'd8;
    localparam step_t S_WALK_EM = 4'd9;

    typedef enum logic [1:0] {
        RD_ANC = 2'd0,
        RD_ENT = 2'd1,
        RD_CUR = 2'd2
    } rd_sel_t;

    typedef enum logic [2:0] {
        DP_NONE      = 3'd0,
        DP_INS_NEW   = 3'd1,
        DP_INS_LINK  = 3'd2,
        DP_REMOVE    = 3'd3,
        DP_WALK_INIT = 3'd4,
        DP_WALK_ADV  = 3'd5
    } dp_op_t;

    typedef enum logic [1:0] {
        EM_NONE   = 2'd0,
        EM_STATUS = 2'd1,
        EM_ENTRY  = 2'd2
    } emit_t;

    typedef enum logic [2:0] {
        J_NEXT      = 3'd0,
        J_DISPATCH  = 3'd1,
        J_IF_BAD    = 3'd2,
        J_IF_ABSENT = 3'd3,
        J_IF_EMPTY  = 3'd4,
        J_GOTO      = 3'd5,
        J_WALK      = 3'd6
    } jump_t;

    typedef struct packed {
        rd_sel_t rd;
        dp_op_t  dp;
        emit_t   em;
        jump_t   jmp;
        step_t   tgt;
    } ctrl_t;

    function automatic ctrl_t ucode(input step_t pc);
        ctrl_t w;
        w = '{rd: RD_ANC, dp: DP_NONE, em: EM_NONE, jmp: J_GOTO, tgt: S_FETCH};
        unique case (pc)
            S_FETCH:   w = '{rd: RD_ANC, dp: DP_NONE,      em: EM_NONE,
                             jmp: J_DISPATCH,  tgt: S_FETCH};
            S_INS_RD:  w = '{rd: RD_ANC, dp: DP_NONE,      em: EM_NONE,
                             jmp: J_IF_BAD,    tgt: S_EMIT};
            S_INS_W1:  w = '{rd: RD_ANC, dp: DP_INS_NEW,   em: EM_NONE,
                             jmp: J_NEXT,      tgt: S_FETCH};
            S_INS_W2:  w = '{rd: RD_ANC, dp: DP_INS_LINK,  em: EM_NONE,
                             jmp: J_GOTO,      tgt: S_EMIT};
            S_REM_RD:  w = '{rd: RD_ENT, dp: DP_NONE,      em: EM_NONE,
                             jmp: J_IF_ABSENT, tgt: S_EMIT};
            S_REM_W:   w = '{rd: RD_ENT, dp: DP_REMOVE,    em: EM_NONE,
                             jmp: J_GOTO,      tgt: S_EMIT};
            S_EMIT:    w = '{rd: RD_ANC, dp: DP_NONE,      em: EM_STATUS,
                             jmp: J_GOTO,      tgt: S_FETCH};
            S_WALK_ST: w = '{rd: RD_CUR, dp: DP_WALK_INIT, em: EM_NONE,
                             jmp: J_IF_EMPTY,  tgt: S_EMIT};
            S_WALK_RD: w = '{rd: RD_CUR, dp: DP_NONE,      em: EM_NONE,
                             jmp: J_NEXT,      tgt: S_FETCH};
            S_WALK_EM: w = '{rd: RD_CUR, dp: DP_WALK_ADV,  em: EM_ENTRY,
                             jmp: J_WALK,      tgt: S_WALK_RD};
            default:   w = '{rd: RD_ANC, dp: DP_NONE,      em: EM_NONE,
                             jmp: J_GOTO,      tgt: S_FETCH};
        endcase
        return w;
    endfunction

endpackage

[rtl/dlle_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dlle_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/doubly_linked_list_engine.sv]
// Each request runs through microprogram steps: insert reads the anchor's links, writes the
// new entry's links, then links the anchor and neighbour and emits its status; remove reads
// the entry's links and relinks its neighbours; a bad insert or absent remove goes straight to
// the status. A walk emits each listed entry after a registered read of the link RAMs, or one
// status result for an empty list. An emitting step waits while the last result is not taken.
// Asynchronous active-low reset: entry 1 alone in the list, no clearing pass needed.
// Top level of the doubly linked list engine; uses dlle_pkg and dlle_ram.
module doubly_linked_list_engine #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [1:0] operation, [8:2] anchor_id, [15:9] entry_id
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [6:0] list_entry, [8:7] status, [15:9] zero
    output logic        m_axis_tlast    // last_of_run
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int PAD_W = dlle_pkg::OUT_W - dlle_pkg::ID_W - dlle_pkg::STATUS_W;

    dlle_pkg::step_t   pc_reg, pc_next;
    dlle_pkg::ctrl_t   cw;
    dlle_pkg::op_t     op_reg, op_next;
    dlle_pkg::id_t     anc_reg, anc_next;
    dlle_pkg::id_t     ent_reg, ent_next;
    dlle_pkg::id_t     head_reg, head_next;
    dlle_pkg::id_t     cur_reg, cur_next;
    dlle_pkg::id_t     nb_reg, nb_next;
    logic [AW-1:0]     count_reg, count_next;
    dlle_pkg::status_t status_reg, status_next;
    logic [MAX_ENTRIES-1:0] present_reg, present_next;
    logic [MAX_ENTRIES-1:0] prev_valid_reg, prev_valid_next;
    logic [MAX_ENTRIES-1:0] next_valid_reg, next_valid_next;
    logic              prev_rdv_reg, next_rdv_reg;

    logic              out_valid_reg, out_valid_next;
    dlle_pkg::id_t     out_entry_reg, out_entry_next;
    dlle_pkg::status_t out_status_reg, out_status_next;
    logic              out_last_reg, out_last_next;

    dlle_pkg::id_t     rd_id;
    logic [AW-1:0]     raddr;
    dlle_pkg::id_t     prev_rd, next_rd, prev_q, next_q, nb;
    logic              prev_we, next_we;
    logic [AW-1:0]     prev_waddr, next_waddr;
    dlle_pkg::id_t     prev_wdata, next_wdata;

    logic              accept, stall, left, anc_ok, ent_in, ent_pres, bad, walk_last;

    function automatic logic [AW-1:0] idx(input dlle_pkg::id_t id);
        return AW'(id - dlle_pkg::id_t'(1));
    endfunction

    function automatic logic in_range(input dlle_pkg::id_t id);
        return (id != '0) && (id <= dlle_pkg::id_t'(MAX_ENTRIES));
    endfunction

    dlle_ram #(.WIDTH(dlle_pkg::ID_W), .DEPTH(MAX_ENTRIES)) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (raddr),
        .rdata (prev_rd)
    );

    dlle_ram #(.WIDTH(dlle_pkg::ID_W), .DEPTH(MAX_ENTRIES)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (raddr),
        .rdata (next_rd)
    );

    assign cw            = dlle_pkg::ucode(pc_reg);
    assign s_axis_tready = (cw.jmp == dlle_pkg::J_DISPATCH);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign stall         = (cw.em != dlle_pkg::EM_NONE) && out_valid_reg && !m_axis_tready;
    assign left          = (op_reg == dlle_pkg::OP_INS_LEFT);

    // links of an entry never written since reset read as zero
    assign prev_q = prev_rdv_reg ? prev_rd : '0;
    assign next_q = next_rdv_reg ? next_rd : '0;
    assign nb     = left ? prev_q : next_q;

    assign anc_ok    = in_range(anc_reg) && present_reg[idx(anc_reg)];
    assign ent_in    = in_range(ent_reg);
    assign ent_pres  = ent_in && present_reg[idx(ent_reg)];
    assign bad       = !anc_ok || !ent_in || ent_pres;
    assign walk_last = (next_q == '0) || (count_reg == AW'(MAX_ENTRIES - 1));

    always_comb
    begin
        case (cw.rd)
            dlle_pkg::RD_ANC: rd_id = anc_reg;
            dlle_pkg::RD_ENT: rd_id = ent_reg;
            dlle_pkg::RD_CUR: rd_id = cur_reg;
            default:          rd_id = cur_reg;
        endcase
        raddr = idx(rd_id);
    end

    always_comb
    begin
        pc_next         = pc_reg;
        op_next         = op_reg;
        anc_next        = anc_reg;
        ent_next        = ent_reg;
        head_next       = head_reg;
        cur_next        = cur_reg;
        nb_next         = nb_reg;
        count_next      = count_reg;
        status_next     = status_reg;
        present_next    = present_reg;
        prev_valid_next = prev_valid_reg;
        next_valid_next = next_valid_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_entry_next  = out_entry_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        prev_we         = 1'b0;
        next_we         = 1'b0;
        prev_waddr      = idx(ent_reg);
        next_waddr      = idx(ent_reg);
        prev_wdata      = '0;
        next_wdata      = '0;

        if (!stall)
        begin
            case (cw.dp)
                dlle_pkg::DP_INS_NEW:
                begin
                    nb_next    = nb;
                    prev_we    = 1'b1;
                    next_we    = 1'b1;
                    prev_wdata = left ? nb : anc_reg;
                    next_wdata = left ? anc_reg : nb;
                end
                dlle_pkg::DP_INS_LINK:
                begin
                    present_next[idx(ent_reg)] = 1'b1;
                    if (left)
                    begin
                        prev_we    = 1'b1;
                        prev_waddr = idx(anc_reg);
                        prev_wdata = ent_reg;
                        if (nb_reg != '0)
                        begin
                            next_we    = 1'b1;
                            next_waddr = idx(nb_reg);
                            next_wdata = ent_reg;
                        end
                        else
                        begin
                            head_next = ent_reg;
                        end
                    end
                    else
                    begin
                        next_we    = 1'b1;
                        next_waddr = idx(anc_reg);
                        next_wdata = ent_reg;
                        if (nb_reg != '0)
                        begin
                            prev_we    = 1'b1;
                            prev_waddr = idx(nb_reg);
                            prev_wdata = ent_reg;
                        end
                    end
                end
                dlle_pkg::DP_REMOVE:
                begin
                    present_next[idx(ent_reg)] = 1'b0;
                    if (prev_q != '0)
                    begin
                        next_we    = 1'b1;
                        next_waddr = idx(prev_q);
                        next_wdata = next_q;
                    end
                    else
                    begin
                        head_next = next_q;
                    end
                    if (next_q != '0)
                    begin
                        prev_we    = 1'b1;
                        prev_waddr = idx(next_q);
                        prev_wdata = prev_q;
                    end
                end
                dlle_pkg::DP_WALK_INIT:
                begin
                    cur_next   = head_reg;
                    count_next = '0;
                end
                dlle_pkg::DP_WALK_ADV:
                begin
                    cur_next   = next_q;
                    count_next = count_reg + AW'(1);
                end
                default:
                begin
                end
            endcase

            if (prev_we)
            begin
                prev_valid_next[prev_waddr] = 1'b1;
            end
            if (next_we)
            begin
                next_valid_next[next_waddr] = 1'b1;
            end

            case (cw.em)
                dlle_pkg::EM_STATUS:
                begin
                    out_valid_next  = 1'b1;
                    out_entry_next  = '0;
                    out_status_next = status_reg;
                    out_last_next   = 1'b1;
                end
                dlle_pkg::EM_ENTRY:
                begin
                    out_valid_next  = 1'b1;
                    out_entry_next  = cur_reg;
                    out_status_next = dlle_pkg::ST_DONE;
                    out_last_next   = walk_last;
                end
                default:
                begin
                end
            endcase

            case (cw.jmp)
                dlle_pkg::J_NEXT:
                begin
                    pc_next = pc_reg + dlle_pkg::step_t'(1);
                end
                dlle_pkg::J_DISPATCH:
                begin
                    if (accept)
                    begin
                        op_next     = dlle_pkg::op_t'(s_axis_tdata[1:0]);
                        anc_next    = s_axis_tdata[8:2];
                        ent_next    = s_axis_tdata[15:9];
                        status_next = dlle_pkg::ST_DONE;
                        unique case (dlle_pkg::op_t'(s_axis_tdata[1:0]))
                            dlle_pkg::OP_INS_LEFT,
                            dlle_pkg::OP_INS_RIGHT: pc_next = dlle_pkg::S_INS_RD;
                            dlle_pkg::OP_REMOVE:    pc_next = dlle_pkg::S_REM_RD;
                            dlle_pkg::OP_WALK:      pc_next = dlle_pkg::S_WALK_ST;
                            default:                pc_next = dlle_pkg::S_FETCH;
                        endcase
                    end
                end
                dlle_pkg::J_IF_BAD:
                begin
                    if (bad)
                    begin
                        pc_next     = cw.tgt;
                        status_next = dlle_pkg::ST_BAD_INSERT;
                    end
                    else
                    begin
                        pc_next = pc_reg + dlle_pkg::step_t'(1);
                    end
                end
                dlle_pkg::J_IF_ABSENT:
                begin
                    if (!ent_pres)
                    begin
                        pc_next     = cw.tgt;
                        status_next = dlle_pkg::ST_ABSENT;
                    end
                    else
                    begin
                        pc_next = pc_reg + dlle_pkg::step_t'(1);
                    end
                end
                dlle_pkg::J_IF_EMPTY:
                begin
                    pc_next = (head_reg == '0) ? cw.tgt : pc_reg + dlle_pkg::step_t'(1);
                end
                dlle_pkg::J_WALK:
                begin
                    pc_next = walk_last ? dlle_pkg::S_FETCH : cw.tgt;
                end
                default:
                begin
                    pc_next = cw.tgt;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg         <= dlle_pkg::S_FETCH;
            head_reg       <= dlle_pkg::id_t'(1);
            present_reg    <= MAX_ENTRIES'(1);
            prev_valid_reg <= '0;
            next_valid_reg <= '0;
            status_reg     <= dlle_pkg::ST_DONE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pc_reg         <= pc_next;
            head_reg       <= head_next;
            present_reg    <= present_next;
            prev_valid_reg <= prev_valid_next;
            next_valid_reg <= next_valid_next;
            status_reg     <= status_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        anc_reg        <= anc_next;
        ent_reg        <= ent_next;
        cur_reg        <= cur_next;
        nb_reg         <= nb_next;
        count_reg      <= count_next;
        prev_rdv_reg   <= prev_valid_reg[raddr];
        next_rdv_reg   <= next_valid_reg[raddr];
        out_entry_reg  <= out_entry_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_status_reg, out_entry_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

[rtl/dlle_checker.sv]
// Port-level checker for the doubly linked list engine, bound to the top level.
// Uses dlle_pkg status codes; attaches to doubly_linked_list_engine.
module dlle_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // one request at a time
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while busy");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            m_axis_tdata[8:7] == dlle_pkg::ST_DONE ||
            m_axis_tdata[8:7] == dlle_pkg::ST_BAD_INSERT ||
            m_axis_tdata[8:7] == dlle_pkg::ST_ABSENT)
        else $error("undefined status code");

    a_entry_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[6:0] != 7'd0 |->
            m_axis_tdata[8:7] == dlle_pkg::ST_DONE)
        else $error("walk entry with error status");

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[8:7] != dlle_pkg::ST_DONE |-> m_axis_tlast)
        else $error("error result not marked last");

endmodule

bind doubly_linked_list_engine dlle_checker u_dlle_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

[bench/tb_doubly_linked_list_engine.sv]
// Self-checking bench for doubly_linked_list_engine: a stimulus table, then random
// insert/remove/walk requests and a tear-down to an empty list, scored by a list model.
// Depends on dlle_pkg and the engine RTL only.
module tb_doubly_linked_list_engine;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ID = 64;
    localparam int RANDOM_LEN = 180;

    typedef struct packed {
        dlle_pkg::id_t     entry;
        dlle_pkg::status_t status;
        logic              last;
    } result_t;

    typedef struct packed {
        dlle_pkg::op_t op;
        dlle_pkg::id_t anc;
        dlle_pkg::id_t ent;
        logic          typed;
        result_t       want;
    } row_t;

    localparam int SCRIPT_LEN = 23;
    localparam row_t SCRIPT [SCRIPT_LEN] = '{
        '{dlle_pkg::OP_WALK, 7'd0, 7'd0, 1'b1, '{7'd1, dlle_pkg::ST_DONE, 1'b1}},
        '{dlle_pkg::OP_INS_RIGHT, 7'd1, 7'd1, 1'b1, '{7'd0, dlle_pkg::ST_BAD_INSERT, 1'b1}},
        '{dlle_pkg::OP_INS_LEFT, 7'd0, 7'd2, 1'b1, '{7'd0, dlle_pkg::ST_BAD_INSERT, 1'b1}},
        '{dlle_pkg::OP_INS_RIGHT, 7'd127, 7'd2, 1'b1, '{7'd0, dlle_pkg::ST_BAD_INSERT, 1'b1}},
        '{dlle_pkg::OP_INS_LEFT, 7'd1, 7'd0, 1'b1, '{7'd0, dlle_pkg::ST_BAD_INSERT, 1'b1}},
        '{dlle_pkg::OP_INS_RIGHT, 7'd1, 7'd65, 1'b1, '{7'd0, dlle_pkg::ST_BAD_INSERT, 1'b1}},
        '{dlle_pkg::OP_INS_LEFT, 7'd1, 7'd127, 1'b1, '{7'd0, dlle_pkg::ST_BAD_INSERT, 1'b1}},
        '{dlle_pkg::OP_INS_RIGHT, 7'd9, 7'd9, 1'b1, '{7'd0, dlle_pkg::ST_BAD_INSERT, 1'b1}},
        '{dlle_pkg::OP_INS_LEFT, 7'd1, 7'd1, 1'b1, '{7'd0, dlle_pkg::ST_BAD_INSERT, 1'b1}},
        '{dlle_pkg::OP_REMOVE, 7'd0, 7'd0, 1'b1, '{7'd0, dlle_pkg::ST_ABSENT, 1'b1}},
        '{dlle_pkg::OP_REMOVE, 7'd127, 7'd127, 1'b1, '{7'd0, dlle_pkg::ST_ABSENT, 1'b1}},
        '{dlle_pkg::OP_REMOVE, 7'd1, 7'd64, 1'b1, '{7'd0, dlle_pkg::ST_ABSENT, 1'b1}},
        '{dlle_pkg::OP_INS_RIGHT, 7'd1, 7'd64, 1'b0, '0},
        '{dlle_pkg::OP_INS_LEFT, 7'd1, 7'd2, 1'b0, '0},
        '{dlle_pkg::OP_INS_RIGHT, 7'd64, 7'd63, 1'b0, '0},
        '{dlle_pkg::OP_INS_LEFT, 7'd64, 7'd3, 1'b0, '0},
        '{dlle_pkg::OP_INS_RIGHT, 7'd2, 7'd4, 1'b0, '0},
        '{dlle_pkg::OP_WALK, 7'd0, 7'd0, 1'b0, '0},
        '{dlle_pkg::OP_REMOVE, 7'd0, 7'd2, 1'b0, '0},
        '{dlle_pkg::OP_REMOVE, 7'd0, 7'd63, 1'b0, '0},
        '{dlle_pkg::OP_REMOVE, 7'd0, 7'd3, 1'b0, '0},
        '{dlle_pkg::OP_WALK, 7'd0, 7'd0, 1'b0, '0},
        '{dlle_pkg::OP_WALK, 7'd127, 7'd127, 1'b0, '0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;     // [1:0] operation, [8:2] anchor_id, [15:9] entry_id
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [6:0] list_entry, [8:7] status, [15:9] zero
    logic        m_axis_tlast;          // last_of_run

    // list model
    dlle_pkg::id_t prev_tab [0:MAX_ID];
    dlle_pkg::id_t next_tab [0:MAX_ID];
    logic          present_map [0:MAX_ID];
    dlle_pkg::id_t head_id;
    int            list_len;
    result_t       new_results [$];

    result_t pending_results [$];
    int      errors = 0;
    int      hold_cycles = 0;
    bit      steady = 1'b0;

    doubly_linked_list_engine #(.MAX_ENTRIES(MAX_ID)) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic bit in_range(dlle_pkg::id_t id);
        return id >= 1 && id <= MAX_ID;
    endfunction

    function automatic bit is_present(dlle_pkg::id_t id);
        return in_range(id) && present_map[id];
    endfunction

    function automatic result_t make_result(dlle_pkg::id_t e, dlle_pkg::status_t s, logic l);
        result_t r;
        r.entry  = e;
        r.status = s;
        r.last   = l;
        return r;
    endfunction

    function automatic void clear_list();
        for (int i = 0; i <= MAX_ID; i++)
        begin
            prev_tab[i]    = '0;
            next_tab[i]    = '0;
            present_map[i] = 1'b0;
        end
        present_map[1] = 1'b1;
        head_id  = 7'd1;
        list_len = 1;
    endfunction

    // updates the list and leaves the results the request causes in new_results
    function automatic void apply_request(dlle_pkg::op_t op, dlle_pkg::id_t anc,
                                          dlle_pkg::id_t ent);
        dlle_pkg::id_t     nb, p, n, cur;
        int                count;
        dlle_pkg::status_t st;
        new_results.delete();
        st = dlle_pkg::ST_DONE;
        case (op)
            dlle_pkg::OP_WALK:
            begin
                cur = head_id;
                if (!in_range(cur))
                    new_results.push_back(make_result('0, dlle_pkg::ST_DONE, 1'b1));
                count = 0;
                while (in_range(cur) && count < MAX_ID)
                begin
                    n = next_tab[cur];
                    new_results.push_back(make_result(cur, dlle_pkg::ST_DONE,
                                                      logic'(n == 0 || count + 1 >= MAX_ID)));
                    count++;
                    cur = n;
                end
            end
            dlle_pkg::OP_REMOVE:
            begin
                if (!is_present(ent))
                    st = dlle_pkg::ST_ABSENT;
                else
                begin
                    p = prev_tab[ent];
                    n = next_tab[ent];
                    if (p != 0)
                        next_tab[p] = n;
                    else
                        head_id = n;
                    if (n != 0)
                        prev_tab[n] = p;
                    prev_tab[ent]    = '0;
                    next_tab[ent]    = '0;
                    present_map[ent] = 1'b0;
                    list_len--;
                end
                new_results.push_back(make_result('0, st, 1'b1));
            end
            default:
            begin
                if (!is_present(anc) || !in_range(ent) || present_map[ent])
                    st = dlle_pkg::ST_BAD_INSERT;
                else
                begin
                    if (op == dlle_pkg::OP_INS_RIGHT)
                    begin
                        nb = next_tab[anc];
                        next_tab[ent] = nb;
                        prev_tab[ent] = anc;
                        if (nb != 0)
                            prev_tab[nb] = ent;
                        next_tab[anc] = ent;
                    end
                    else
                    begin
                        nb = prev_tab[anc];
                        prev_tab[ent] = nb;
                        next_tab[ent] = anc;
                        if (nb != 0)
                            next_tab[nb] = ent;
                        else
                            head_id = ent;
                        prev_tab[anc] = ent;
                    end
                    present_map[ent] = 1'b1;
                    list_len++;
                end
                new_results.push_back(make_result('0, st, 1'b1));
            end
        endcase
    endfunction

    function automatic dlle_pkg::id_t pick_id(logic want_present);
        dlle_pkg::id_t pool [$];
        for (int i = 1; i <= MAX_ID; i++)
            if (present_map[i] == want_present)
                pool.push_back(dlle_pkg::id_t'(i));
        if (pool.size() == 0)
            return '0;
        return pool[$urandom_range(0, pool.size() - 1)];
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        errors++;
    endtask

    task automatic issue_request(input dlle_pkg::op_t op, input dlle_pkg::id_t anc,
                                 input dlle_pkg::id_t ent, input logic typed,
                                 input result_t want);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ent, anc, op};
        do @(posedge clk); while (!s_axis_tready);
        apply_request(op, anc, ent);
        if (typed)
            pending_results.push_back(want);
        else
            foreach (new_results[i])
                pending_results.push_back(new_results[i]);
    endtask

    // called right at an accept edge
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // result side
    initial
    begin
        int            stall;
        result_t       want;
        dlle_pkg::id_t got_entry;
        logic [1:0]    got_status;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
                stall = hold_cycles;
            else
                stall = steady ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                hold_cycles = 0;
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            got_entry  = m_axis_tdata[6:0];
            got_status = m_axis_tdata[8:7];
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result entry %0d status %0d last %0b",
                                          got_entry, got_status, m_axis_tlast));
            else
            begin
                want = pending_results.pop_front();
                if (got_entry !== want.entry || got_status !== want.status
                        || m_axis_tlast !== want.last || m_axis_tdata[15:9] !== '0)
                    report_mismatch($sformatf(
                        "entry %0d/%0d status %0d/%0d last %0b/%0b pad %h (got/want)",
                        got_entry, want.entry, got_status, want.status,
                        m_axis_tlast, want.last, m_axis_tdata[15:9]));
            end
        end
    end

    initial
    begin
        dlle_pkg::op_t op;
        dlle_pkg::id_t anc, ent;
        int            r;
        bit            filling;
        clear_list();
        filling = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < SCRIPT_LEN; i++)
            issue_request(SCRIPT[i].op, SCRIPT[i].anc, SCRIPT[i].ent,
                          SCRIPT[i].typed, SCRIPT[i].want);

        // grow towards a full list, then drain towards a short one, and repeat
        for (int k = 0; k < RANDOM_LEN; k++)
        begin
            if (k == 60)
                hold_cycles = 400;
            steady = (k >= 100 && k < 140);
            if (k == 150)
                drain_results();
            if (list_len >= MAX_ID)
                filling = 1'b0;
            else if (list_len <= 3)
                filling = 1'b1;
            r   = $urandom_range(0, 99);
            op  = dlle_pkg::op_t'($urandom_range(0, 3));
            anc = dlle_pkg::id_t'($urandom_range(0, 127));
            ent = dlle_pkg::id_t'($urandom_range(0, 127));
            if (r < 10)
                ;   // noise: fields as drawn
            else if (r < 22)
                op = dlle_pkg::OP_WALK;
            else if ($urandom_range(0, 99) < (filling ? 85 : 20))
            begin
                op  = $urandom_range(0, 1) ? dlle_pkg::OP_INS_RIGHT : dlle_pkg::OP_INS_LEFT;
                anc = ($urandom_range(0, 19) == 0) ? pick_id(1'b0) : pick_id(1'b1);
                ent = ($urandom_range(0, 19) == 0) ? pick_id(1'b1) : pick_id(1'b0);
            end
            else
            begin
                op  = dlle_pkg::OP_REMOVE;
                ent = ($urandom_range(0, 9) == 0) ? pick_id(1'b0) : pick_id(1'b1);
            end
            // an emptied list can never be refilled, so that is kept for the tear-down
            if (op == dlle_pkg::OP_REMOVE && list_len == 1 && is_present(ent))
                ent = '0;
            issue_request(op, anc, ent, 1'b0, '0);
        end
        steady = 1'b0;

        // tear-down: remove everything, then use the empty list
        drain_results();
        while (list_len > 0)
        begin
            if ($urandom_range(0, 3) == 0)
                issue_request(dlle_pkg::OP_WALK, dlle_pkg::id_t'($urandom_range(0, 127)), '0,
                              1'b0, '0);
            issue_request(dlle_pkg::OP_REMOVE, '0, pick_id(1'b1), 1'b0, '0);
        end
        issue_request(dlle_pkg::OP_WALK, '0, '0, 1'b0, '0);
        issue_request(dlle_pkg::OP_INS_LEFT, 7'd1, 7'd2, 1'b0, '0);
        issue_request(dlle_pkg::OP_INS_RIGHT, 7'd0, 7'd64, 1'b0, '0);
        issue_request(dlle_pkg::OP_REMOVE, '0, 7'd1, 1'b0, '0);
        issue_request(dlle_pkg::OP_WALK, '0, '0, 1'b0, '0);

        drain_results();
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
